[design/nbsc_pkg.sv]
// Shared types, constants and helper functions for the natural break scale classifier.
package nbsc_pkg;

  localparam int SIZE_W = 24;
  localparam int CNT_W  = 7;
  localparam int GIDX_W = 6;
  localparam int LVL_W  = 2;
  localparam int SUM_W  = 26;
  localparam int SQ_W   = 50;
  localparam int D_W    = 52;
  localparam int ROOT_W = 26;
  localparam int DIVD_W = 28;
  localparam int DVSR_W = 4;

  localparam logic [LVL_W-1:0] LVL_SMALL  = 2'd0;
  localparam logic [LVL_W-1:0] LVL_MEDIUM = 2'd1;
  localparam logic [LVL_W-1:0] LVL_LARGE  = 2'd2;

  localparam logic [DVSR_W-1:0] DIV_BY_SIX = 4'd6;
  localparam logic [DVSR_W-1:0] DIV_BY_TEN = 4'd10;

  typedef enum logic [3:0] {
    THR_HOLD, THR_ZERO, THR_RANGE, THR_GAPS,
    THR_SQ0, THR_SQ1, THR_SQ2, THR_SQ3, THR_DIFF
  } thr_op_t;

  typedef enum logic [1:0] {
    DOP_HI, DOP_LO, DOP_SCALE_LG, DOP_SCALE_MD
  } div_op_t;

  typedef enum logic [4:0] {
    ST_LOAD, ST_SORT_I, ST_SORT_IC, ST_SORT_J, ST_SORT_W, ST_SCAN, ST_FORM,
    ST_SQ1, ST_SQ2, ST_SQ3, ST_DIFF, ST_ROOT_GO, ST_ROOT_WAIT,
    ST_DHI_GO, ST_DHI_WAIT, ST_DLO_GO, ST_DLO_WAIT, ST_COUNT, ST_CHECK,
    ST_SL_GO, ST_SL_WAIT, ST_SM_GO, ST_SM_WAIT,
    ST_EMIT_RD, ST_EMIT_LD, ST_EMIT_WAIT
  } state_t;

  typedef struct packed {
    logic             load;
    logic [CNT_W-1:0] size_addr;
    logic [CNT_W-1:0] sort_addr;
    logic             si_cap;
    logic             rank_clr;
    logic             rank_en;
    logic [CNT_W-1:0] cmp_idx;
    logic [CNT_W-1:0] self_idx;
    logic             sort_wr;
    logic             scan_clr;
    logic             scan_en;
    logic [CNT_W-1:0] scan_idx;
    thr_op_t          thr_op;
    logic             root_start;
    logic             div_start;
    div_op_t          div_op;
    logic             cnt_clr;
    logic             cnt_en;
    logic             out_load;
    logic [CNT_W-1:0] out_idx;
    logic             out_last;
    logic             batch_clr;
  } nbsc_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] nz;
    logic             root_done;
    logic             div_done;
    logic             scale_need;
    logic             out_fire;
  } nbsc_status_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [DIVD_W-1:0] v);
    logic [SIZE_W-1:0] res;
    if (v[DIVD_W-1:SIZE_W] != '0) begin
      res = '1;
    end else begin
      res = v[SIZE_W-1:0];
    end
    return res;
  endfunction

  function automatic logic [LVL_W-1:0] level_of(input logic [SIZE_W-1:0] s,
                                                 input logic [SIZE_W-1:0] lg,
                                                 input logic [SIZE_W-1:0] md);
    logic [LVL_W-1:0] res;
    if (s >= lg) begin
      res = LVL_LARGE;
    end else if (s >= md) begin
      res = LVL_MEDIUM;
    end else begin
      res = LVL_SMALL;
    end
    return res;
  endfunction

endpackage

[design/nbsc_if.sv]
// Valid/ready channel interfaces for the group sizes and the classification results.
interface nbsc_in_if;
  logic                       valid;
  logic                       ready;
  logic [nbsc_pkg::SIZE_W-1:0] group_size;
  logic                       last_group;
  modport source (output valid, output group_size, output last_group, input ready);
  modport sink (input valid, input group_size, input last_group, output ready);
endinterface

interface nbsc_out_if;
  logic                        valid;
  logic                        ready;
  logic [nbsc_pkg::GIDX_W-1:0] group_index;
  logic [nbsc_pkg::LVL_W-1:0]  size_class;
  logic [nbsc_pkg::SIZE_W-1:0] large_threshold;
  logic [nbsc_pkg::SIZE_W-1:0] medium_threshold;
  logic                        last_result;
  modport source (output valid, output group_index, output size_class,
                  output large_threshold, output medium_threshold,
                  output last_result, input ready);
  modport sink (input valid, input group_index, input size_class,
                input large_threshold, input medium_threshold,
                input last_result, output ready);
endinterface

[design/natural_break_scale_classifier.sv]
// Top level of the natural break scale classifier: controller and datapath.
//
// The in_ch channel carries one group size (unsigned fixed point) per item with a
// last_group flag. Items are taken one per cycle while a batch loads; up to
// MAX_GROUPS are stored and later items are dropped, though a dropped item that
// carries last_group still closes the batch. After the last item the block stops
// taking items, sorts the nonzero sizes by ranking each against all stored sizes,
// scans the sorted store for gaps and derives the thresholds. The three-value
// case adds the statistics, the square root and two divisions by reciprocal
// multiplication. A counting pass over the size store then decides on a
// scale-down of the thresholds, which adds two more divisions. Results leave on
// out_ch in load order, one per group, each through an output register; the next
// result is loaded only after the last one is taken, and a stalled receiver holds
// the register and the sequence. The next batch is accepted once the final result
// of the batch is taken. Reset clears the group count, the thresholds and the
// result valid flag; the stores need no clearing.
module natural_break_scale_classifier #(
  parameter int MAX_GROUPS = 64
) (
  input logic       clk,
  input logic       rst_n,
  nbsc_in_if.sink   in_ch,
  nbsc_out_if.source out_ch
);
  import nbsc_pkg::*;

  nbsc_cmd_t    cmd;
  nbsc_status_t status;

  nbsc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.last_group),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  nbsc_dp #(
    .MAX_GROUPS (MAX_GROUPS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_size    (in_ch.group_size),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_index  (out_ch.group_index),
    .out_level  (out_ch.size_class),
    .out_large  (out_ch.large_threshold),
    .out_medium (out_ch.medium_threshold),
    .out_last   (out_ch.last_result)
  );
endmodule

[design/nbsc_cdiv.sv]
// Divider of a 28-bit value by six or ten using halving and reciprocal multiplication.
module nbsc_cdiv (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [nbsc_pkg::DIVD_W-1:0]  dividend,
  input  logic [nbsc_pkg::DVSR_W-1:0]  divisor,
  output logic                         done,
  output logic [nbsc_pkg::DIVD_W-1:0]  quot
);
  import nbsc_pkg::*;

  localparam int HALF_W = DIVD_W - 1;
  localparam int RCP_W  = 28;
  localparam int RCP_SH = 29;
  localparam int PROD_W = HALF_W + RCP_W;
  localparam logic [RCP_W-1:0] RCP_THIRD = 28'd178956971;
  localparam logic [RCP_W-1:0] RCP_FIFTH = 28'd107374183;

  logic [HALF_W-1:0] half_r;
  logic [RCP_W-1:0]  rcp_r;
  logic [DIVD_W-1:0] quo_r;
  logic              busy_r;
  logic              done_r;
  logic [PROD_W-1:0] prod;

  // Dividing by six or ten is halving followed by an exact reciprocal
  // multiplication by one third or one fifth.
  assign prod = half_r * rcp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= start;
      done_r <= busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      half_r <= dividend[DIVD_W-1:1];
      rcp_r  <= (divisor == DIV_BY_SIX) ? RCP_THIRD : RCP_FIFTH;
    end
    if (busy_r) begin
      quo_r <= {2'b00, prod[PROD_W-1:RCP_SH]};
    end
  end

  assign done = done_r;
  assign quot = quo_r;
endmodule

[design/nbsc_isqrt.sv]
// Iterative integer square root, one result bit per cycle.
module nbsc_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [nbsc_pkg::D_W-1:0]    value,
  output logic                        done,
  output logic [nbsc_pkg::ROOT_W-1:0] root
);
  import nbsc_pkg::*;

  logic [D_W-1:0] v_r;
  logic [D_W-1:0] r_r;
  logic [D_W-1:0] bit_r;
  logic           busy_r;
  logic           done_r;
  logic [D_W-1:0] trial;

  assign trial = r_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r[0]) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= value;
      r_r   <= '0;
      bit_r <= {2'b01, {(D_W-2){1'b0}}};
    end else if (busy_r) begin
      if (v_r >= trial) begin
        v_r <= v_r - trial;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = r_r[ROOT_W-1:0];
endmodule

[design/nbsc_dp.sv]
// Datapath: size and sorted stores, rank sort, gap scan, statistics and result register.
module nbsc_dp #(
  parameter int MAX_GROUPS = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  nbsc_pkg::nbsc_cmd_t          cmd,
  output nbsc_pkg::nbsc_status_t       status,
  input  logic [nbsc_pkg::SIZE_W-1:0]  in_size,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [nbsc_pkg::GIDX_W-1:0]  out_index,
  output logic [nbsc_pkg::LVL_W-1:0]   out_level,
  output logic [nbsc_pkg::SIZE_W-1:0]  out_large,
  output logic [nbsc_pkg::SIZE_W-1:0]  out_medium,
  output logic                         out_last
);
  import nbsc_pkg::*;

  localparam int IW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam logic [CNT_W-1:0] MAXC = CNT_W'(MAX_GROUPS);

  logic [SIZE_W-1:0] size_mem [MAX_GROUPS];
  logic [SIZE_W-1:0] sorted_mem [MAX_GROUPS];
  logic [SIZE_W-1:0] size_q_r;
  logic [SIZE_W-1:0] sort_q_r;

  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  nz_r;
  logic [SIZE_W-1:0] si_r;
  logic [CNT_W-1:0]  rank_r;

  logic [SIZE_W-1:0] lo_r;
  logic [SIZE_W-1:0] hi_r;
  logic [SIZE_W-1:0] val_r [3];
  logic              h1_r;
  logic              h2_r;
  logic [SIZE_W-1:0] b1g_r;
  logic [SIZE_W-1:0] b2g_r;
  logic [CNT_W-1:0]  b1s_r;
  logic [CNT_W-1:0]  b2s_r;
  logic [SIZE_W-1:0] b1v_r;
  logic [SIZE_W-1:0] b2v_r;

  logic [SUM_W-1:0]  sum_r;
  logic [SQ_W-1:0]   sq_r;
  logic [D_W-1:0]    prod_r;
  logic [D_W-1:0]    d_r;
  logic [SIZE_W-1:0] lg_r;
  logic [SIZE_W-1:0] md_r;
  logic [CNT_W-1:0]  lc_r;

  logic              out_valid_r;
  logic [GIDX_W-1:0] out_index_r;
  logic [LVL_W-1:0]  out_level_r;
  logic [SIZE_W-1:0] out_large_r;
  logic [SIZE_W-1:0] out_medium_r;
  logic              out_last_r;

  logic [SUM_W-1:0]  mul_a;
  logic [D_W-1:0]    mul_p;
  logic [SIZE_W-1:0] gap;
  logic [SIZE_W-1:0] range;
  logic [SIZE_W+1:0] range3;
  logic [D_W-1:0]    three_sq;
  logic [DIVD_W-1:0] twice;
  logic [DIVD_W-1:0] root_ext;
  logic [DIVD_W-1:0] div_in;
  logic [DVSR_W-1:0] div_dvsr;
  logic [DIVD_W-1:0] div_quot;
  logic              div_done;
  div_op_t           div_op_r;
  logic [ROOT_W-1:0] root;
  logic              root_done;
  logic              rank_hit;
  logic [CNT_W+1:0]  lc5;
  logic [CNT_W+1:0]  cnt4;

  always_ff @(posedge clk) begin
    if (cmd.load && (cnt_r < MAXC)) begin
      size_mem[cnt_r[IW-1:0]] <= in_size;
    end
    size_q_r <= size_mem[cmd.size_addr[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.sort_wr && (si_r != '0)) begin
      sorted_mem[rank_r[IW-1:0]] <= si_r;
    end
    sort_q_r <= sorted_mem[cmd.sort_addr[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      nz_r  <= '0;
    end else if (cmd.batch_clr) begin
      cnt_r <= '0;
      nz_r  <= '0;
    end else if (cmd.load && (cnt_r < MAXC)) begin
      cnt_r <= cnt_r + 7'd1;
      if (in_size != '0) begin
        nz_r <= nz_r + 7'd1;
      end
    end
  end

  assign rank_hit = (size_q_r != '0) &&
                    ((size_q_r < si_r) || ((size_q_r == si_r) && (cmd.cmp_idx < cmd.self_idx)));

  always_ff @(posedge clk) begin
    if (cmd.si_cap) begin
      si_r <= size_q_r;
    end
    if (cmd.rank_clr) begin
      rank_r <= '0;
    end else if (cmd.rank_en && rank_hit) begin
      rank_r <= rank_r + 7'd1;
    end
  end

  assign gap = sort_q_r - hi_r;

  always_ff @(posedge clk) begin
    if (cmd.scan_clr) begin
      h1_r <= 1'b0;
      h2_r <= 1'b0;
    end else if (cmd.scan_en) begin
      hi_r <= sort_q_r;
      if (cmd.scan_idx == '0) begin
        lo_r <= sort_q_r;
      end
      if (cmd.scan_idx < 7'd3) begin
        val_r[cmd.scan_idx[1:0]] <= sort_q_r;
      end
      if (cmd.scan_idx != '0) begin
        if (!h1_r || (gap > b1g_r)) begin
          h1_r  <= 1'b1;
          h2_r  <= h1_r;
          b2g_r <= b1g_r;
          b2s_r <= b1s_r;
          b2v_r <= b1v_r;
          b1g_r <= gap;
          b1s_r <= cmd.scan_idx;
          b1v_r <= sort_q_r;
        end else if (!h2_r || (gap > b2g_r)) begin
          h2_r  <= 1'b1;
          b2g_r <= gap;
          b2s_r <= cmd.scan_idx;
          b2v_r <= sort_q_r;
        end
      end
    end
  end

  always_comb begin
    unique case (cmd.thr_op)
      THR_SQ0: mul_a = {2'b00, val_r[0]};
      THR_SQ1: mul_a = {2'b00, val_r[1]};
      THR_SQ2: mul_a = {2'b00, val_r[2]};
      default: mul_a = sum_r;
    endcase
  end

  assign mul_p    = mul_a * mul_a;
  assign range    = hi_r - lo_r;
  assign range3   = {2'b00, range} + {1'b0, range, 1'b0};
  assign three_sq = {1'b0, sq_r, 1'b0} + {2'b00, sq_r};
  assign twice    = {1'b0, sum_r, 1'b0};
  assign root_ext = {2'b00, root};

  always_comb begin
    unique case (cmd.div_op)
      DOP_HI: begin
        div_in   = twice + root_ext;
        div_dvsr = DIV_BY_SIX;
      end
      DOP_LO: begin
        div_in   = (twice >= root_ext) ? (twice - root_ext) : '0;
        div_dvsr = DIV_BY_SIX;
      end
      DOP_SCALE_LG: begin
        div_in   = {1'b0, lg_r, 3'b000} - {4'b0000, lg_r};
        div_dvsr = DIV_BY_TEN;
      end
      DOP_SCALE_MD: begin
        div_in   = {1'b0, md_r, 3'b000} - {4'b0000, md_r};
        div_dvsr = DIV_BY_TEN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_op_r <= cmd.div_op;
    end
  end

  nbsc_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.root_start),
    .value (d_r),
    .done  (root_done),
    .root  (root)
  );

  nbsc_cdiv u_cdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_in),
    .divisor  (div_dvsr),
    .done     (div_done),
    .quot     (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lg_r <= '0;
      md_r <= '0;
    end else begin
      unique case (cmd.thr_op)
        THR_ZERO: begin
          lg_r <= '0;
          md_r <= '0;
        end
        THR_RANGE: begin
          lg_r <= clamp_size(DIVD_W'({1'b0, lo_r} + {1'b0, range3[SIZE_W+1:2]}));
          md_r <= clamp_size(DIVD_W'({1'b0, lo_r} + {2'b00, range[SIZE_W-1:1]}));
        end
        THR_GAPS: begin
          lg_r <= (b1s_r > b2s_r) ? b1v_r : b2v_r;
          md_r <= (b1s_r > b2s_r) ? b2v_r : b1v_r;
        end
        THR_SQ0: begin
          sum_r  <= {2'b00, val_r[0]} + {2'b00, val_r[1]} + {2'b00, val_r[2]};
          sq_r   <= '0;
          prod_r <= mul_p;
        end
        THR_SQ1, THR_SQ2, THR_SQ3: begin
          sq_r   <= sq_r + prod_r[SQ_W-1:0];
          prod_r <= mul_p;
        end
        THR_DIFF: begin
          d_r <= (three_sq >= prod_r) ? (three_sq - prod_r) : '0;
        end
        THR_HOLD: begin
          if (div_done) begin
            if ((div_op_r == DOP_HI) || (div_op_r == DOP_SCALE_LG)) begin
              lg_r <= clamp_size(div_quot);
            end else begin
              md_r <= clamp_size(div_quot);
            end
          end
        end
        default: begin
          lg_r <= lg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cnt_clr) begin
      lc_r <= '0;
    end else if (cmd.cnt_en && (size_q_r >= lg_r)) begin
      lc_r <= lc_r + 7'd1;
    end
  end

  assign lc5  = {lc_r, 2'b00} + {2'b00, lc_r};
  assign cnt4 = {cnt_r, 2'b00};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_index_r  <= cmd.out_idx[GIDX_W-1:0];
      out_level_r  <= level_of(size_q_r, lg_r, md_r);
      out_large_r  <= lg_r;
      out_medium_r <= md_r;
      out_last_r   <= cmd.out_last;
    end
  end

  assign status.cnt        = cnt_r;
  assign status.nz         = nz_r;
  assign status.root_done  = root_done;
  assign status.div_done   = div_done;
  assign status.scale_need = lc5 > cnt4;
  assign status.out_fire   = out_valid_r && out_ready;

  assign out_valid  = out_valid_r;
  assign out_index  = out_index_r;
  assign out_level  = out_level_r;
  assign out_large  = out_large_r;
  assign out_medium = out_medium_r;
  assign out_last   = out_last_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= MAXC)
    else $error("group count exceeds store depth");
  a_nz_bound: assert property (@(posedge clk) disable iff (!rst_n) nz_r <= cnt_r)
    else $error("nonzero count exceeds group count");
  a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.sort_wr && (si_r != '0)) |-> (rank_r < nz_r))
    else $error("sort rank outside nonzero range");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !out_valid_r)
    else $error("result register overwritten before it was taken");
endmodule

[design/nbsc_ctrl.sv]
// Controller state machine sequencing load, sort, threshold, count and emit phases.
module nbsc_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_last,
  output logic                   in_ready,
  input  nbsc_pkg::nbsc_status_t status,
  output nbsc_pkg::nbsc_cmd_t    cmd
);
  import nbsc_pkg::*;

  state_t           state_r;
  state_t           state_nxt;
  logic [CNT_W-1:0] i_r;
  logic [CNT_W-1:0] i_nxt;
  logic [CNT_W-1:0] j_r;
  logic [CNT_W-1:0] j_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      i_r     <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.thr_op = THR_HOLD;
    cmd.div_op = DOP_HI;
    unique case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid && in_last) begin
          i_nxt     = '0;
          state_nxt = ST_SORT_I;
        end
      end
      ST_SORT_I: begin
        cmd.size_addr = i_r;
        state_nxt     = ST_SORT_IC;
      end
      ST_SORT_IC: begin
        cmd.si_cap   = 1'b1;
        cmd.rank_clr = 1'b1;
        j_nxt        = '0;
        state_nxt    = ST_SORT_J;
      end
      ST_SORT_J: begin
        cmd.size_addr = j_r;
        cmd.rank_en   = (j_r != '0);
        cmd.cmp_idx   = j_r - 7'd1;
        cmd.self_idx  = i_r;
        if (j_r == status.cnt) begin
          state_nxt = ST_SORT_W;
        end else begin
          j_nxt = j_r + 7'd1;
        end
      end
      ST_SORT_W: begin
        cmd.sort_wr  = 1'b1;
        cmd.scan_clr = 1'b1;
        if (i_r + 7'd1 == status.cnt) begin
          j_nxt     = '0;
          state_nxt = ST_SCAN;
        end else begin
          i_nxt     = i_r + 7'd1;
          state_nxt = ST_SORT_I;
        end
      end
      ST_SCAN: begin
        cmd.sort_addr = j_r;
        cmd.scan_en   = (j_r != '0);
        cmd.scan_idx  = j_r - 7'd1;
        if (j_r == status.nz) begin
          state_nxt = ST_FORM;
        end else begin
          j_nxt = j_r + 7'd1;
        end
      end
      ST_FORM: begin
        j_nxt     = '0;
        state_nxt = ST_COUNT;
        priority if (status.nz == '0) begin
          cmd.thr_op = THR_ZERO;
        end else if (status.nz < 7'd3) begin
          cmd.thr_op = THR_RANGE;
        end else if (status.nz == 7'd3) begin
          cmd.thr_op = THR_SQ0;
          state_nxt  = ST_SQ1;
        end else begin
          cmd.thr_op = THR_GAPS;
        end
      end
      ST_SQ1: begin
        cmd.thr_op = THR_SQ1;
        state_nxt  = ST_SQ2;
      end
      ST_SQ2: begin
        cmd.thr_op = THR_SQ2;
        state_nxt  = ST_SQ3;
      end
      ST_SQ3: begin
        cmd.thr_op = THR_SQ3;
        state_nxt  = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.thr_op = THR_DIFF;
        state_nxt  = ST_ROOT_GO;
      end
      ST_ROOT_GO: begin
        cmd.root_start = 1'b1;
        state_nxt      = ST_ROOT_WAIT;
      end
      ST_ROOT_WAIT: begin
        if (status.root_done) begin
          state_nxt = ST_DHI_GO;
        end
      end
      ST_DHI_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DOP_HI;
        state_nxt     = ST_DHI_WAIT;
      end
      ST_DHI_WAIT: begin
        if (status.div_done) begin
          state_nxt = ST_DLO_GO;
        end
      end
      ST_DLO_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DOP_LO;
        state_nxt     = ST_DLO_WAIT;
      end
      ST_DLO_WAIT: begin
        if (status.div_done) begin
          j_nxt     = '0;
          state_nxt = ST_COUNT;
        end
      end
      ST_COUNT: begin
        cmd.size_addr = j_r;
        cmd.cnt_clr   = (j_r == '0);
        cmd.cnt_en    = (j_r != '0);
        if (j_r == status.cnt) begin
          state_nxt = ST_CHECK;
        end else begin
          j_nxt = j_r + 7'd1;
        end
      end
      ST_CHECK: begin
        i_nxt = '0;
        if (status.scale_need) begin
          state_nxt = ST_SL_GO;
        end else begin
          state_nxt = ST_EMIT_RD;
        end
      end
      ST_SL_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DOP_SCALE_LG;
        state_nxt     = ST_SL_WAIT;
      end
      ST_SL_WAIT: begin
        if (status.div_done) begin
          state_nxt = ST_SM_GO;
        end
      end
      ST_SM_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DOP_SCALE_MD;
        state_nxt     = ST_SM_WAIT;
      end
      ST_SM_WAIT: begin
        if (status.div_done) begin
          i_nxt     = '0;
          state_nxt = ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: begin
        cmd.size_addr = i_r;
        state_nxt     = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        cmd.out_load = 1'b1;
        cmd.out_idx  = i_r;
        cmd.out_last = (i_r + 7'd1 == status.cnt);
        state_nxt    = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: begin
        if (status.out_fire) begin
          if (i_r + 7'd1 == status.cnt) begin
            cmd.batch_clr = 1'b1;
            state_nxt     = ST_LOAD;
          end else begin
            i_nxt     = i_r + 7'd1;
            state_nxt = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end
endmodule

[dv/nbsc_scoreboard.sv]
// Scoreboard class that predicts classification results per batch and checks them.
package nbsc_tb_pkg;
  import nbsc_pkg::*;

  typedef struct packed {
    logic [GIDX_W-1:0] group_index;
    logic [LVL_W-1:0]  size_class;
    logic [SIZE_W-1:0] large_threshold;
    logic [SIZE_W-1:0] medium_threshold;
    logic              last_result;
  } level_result_t;

  class level_scoreboard;
    int unsigned max_groups = 64;
    logic [SIZE_W-1:0] batch_sizes[$];
    level_result_t pending_levels[$];
    int errors = 0;

    function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function automatic logic [LVL_W-1:0] grade(logic [SIZE_W-1:0] s, logic [SIZE_W-1:0] lg,
                                              logic [SIZE_W-1:0] md);
      if (s >= lg) return LVL_LARGE;
      if (s >= md) return LVL_MEDIUM;
      return LVL_SMALL;
    endfunction

    function automatic logic [SIZE_W-1:0] sat24(longint unsigned v);
      return (v > 64'hFFFFFF) ? 24'hFFFFFF : v[SIZE_W-1:0];
    endfunction

    function void note_group(logic [SIZE_W-1:0] size, logic last);
      longint unsigned srt[$];
      longint unsigned lg, md, s, sq, d, q, g, best;
      int n, g1, g2, nlarge, total;
      bit have;
      level_result_t r;
      if (batch_sizes.size() < max_groups) batch_sizes.insert(batch_sizes.size(), size);
      if (!last) return;
      foreach (batch_sizes[i]) if (batch_sizes[i] != 0) srt.insert(srt.size(), batch_sizes[i]);
      srt.sort();
      n = srt.size();
      if (n == 0) begin
        lg = 0; md = 0;
      end else if (n >= 4) begin
        have = 0; g1 = 0; best = 0;
        for (int i = 0; i + 1 < n; i++) begin
          g = srt[i+1] - srt[i];
          if (!have || g > best) begin best = g; g1 = i; have = 1; end
        end
        have = 0; g2 = 0;
        for (int i = 0; i + 1 < n; i++) begin
          g = srt[i+1] - srt[i];
          if (i != g1 && (!have || g > best)) begin best = g; g2 = i; have = 1; end
        end
        lg = srt[(g1 > g2 ? g1 : g2) + 1];
        md = srt[(g1 < g2 ? g1 : g2) + 1];
      end else if (n == 3) begin
        s = 0; sq = 0;
        foreach (srt[i]) begin s += srt[i]; sq += srt[i] * srt[i]; end
        d = 3 * sq;
        d = (d >= s * s) ? d - s * s : 0;
        q = int_sqrt(d);
        lg = sat24((2 * s + q) / 6);
        md = sat24((2 * s >= q) ? (2 * s - q) / 6 : 0);
      end else begin
        lg = sat24(srt[0] + ((srt[n-1] - srt[0]) * 3) / 4);
        md = sat24(srt[0] + (srt[n-1] - srt[0]) / 2);
      end
      total = batch_sizes.size();
      nlarge = 0;
      foreach (batch_sizes[i]) if (grade(batch_sizes[i], lg, md) == LVL_LARGE) nlarge++;
      if (nlarge * 5 > total * 4) begin
        lg = (lg * 7) / 10;
        md = (md * 7) / 10;
      end
      foreach (batch_sizes[i]) begin
        r.group_index = i[GIDX_W-1:0];
        r.size_class = grade(batch_sizes[i], lg, md);
        r.large_threshold = lg[SIZE_W-1:0];
        r.medium_threshold = md[SIZE_W-1:0];
        r.last_result = (i + 1 == total);
        pending_levels.insert(pending_levels.size(), r);
      end
      batch_sizes.delete();
    endfunction

    function void check_level(level_result_t got);
      level_result_t e;
      if (pending_levels.size() == 0) begin
        $error("unexpected result index %0d", got.group_index);
        errors++;
        return;
      end
      e = pending_levels.pop_front();
      if (got.group_index !== e.group_index) begin
        $error("group_index exp %0d got %0d", e.group_index, got.group_index); errors++;
      end
      if (got.size_class !== e.size_class) begin
        $error("size_class exp %0d got %0d", e.size_class, got.size_class); errors++;
      end
      if (got.large_threshold !== e.large_threshold) begin
        $error("large_threshold exp %h got %h", e.large_threshold, got.large_threshold);
        errors++;
      end
      if (got.medium_threshold !== e.medium_threshold) begin
        $error("medium_threshold exp %h got %h", e.medium_threshold, got.medium_threshold);
        errors++;
      end
      if (got.last_result !== e.last_result) begin
        $error("last_result exp %0d got %0d", e.last_result, got.last_result); errors++;
      end
    endfunction
  endclass
endpackage

[dv/testbench.sv]
// Top-level testbench that drives batches of group sizes and checks the levels.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import nbsc_pkg::*;
  import nbsc_tb_pkg::*;

  logic clk;
  logic rst_n;
  nbsc_in_if in_ch();
  nbsc_out_if out_ch();
  level_scoreboard levels;
  int items_sent;
  bit sending_done;
  bit hold_off;

  natural_break_scale_classifier u_top (.clk(clk), .rst_n(rst_n), .in_ch(in_ch),
                                        .out_ch(out_ch));

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  task automatic send_group(logic [SIZE_W-1:0] size, logic last);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.group_size <= size;
    in_ch.last_group <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    levels.note_group(size, last);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_batch(logic [SIZE_W-1:0] sizes[$]);
    foreach (sizes[i]) send_group(sizes[i], i == sizes.size() - 1);
  endtask

  function automatic logic [SIZE_W-1:0] rand_size();
    unique case ($urandom_range(0, 5))
      0: return 0;
      1: return SIZE_W'(24'hFFFFFF - $urandom_range(0, 3));
      2: return SIZE_W'($urandom_range(0, 15));
      3: return SIZE_W'($urandom_range(0, 255) << 8);
      default: return SIZE_W'($urandom());
    endcase
  endfunction

  initial begin
    logic [SIZE_W-1:0] b[$];
    int len;
    levels = new();
    in_ch.valid = 0;
    in_ch.group_size = 0;
    in_ch.last_group = 0;
    rst_n = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    b = '{24'd0};                                  send_batch(b);
    b = '{24'hFFFFFF};                             send_batch(b);
    b = '{24'd5, 24'hFFFFFF};                      send_batch(b);
    b = '{24'd100, 24'd0, 24'd200, 24'd400};       send_batch(b);
    b = '{24'hFFFFFF, 24'hFFFFFE, 24'hAAAAAA};     send_batch(b);
    b = '{24'd10, 24'd10, 24'd10, 24'd10, 24'd1};  send_batch(b);
    b = '{24'd1, 24'd2, 24'd3, 24'd4, 24'd5};      send_batch(b);
    b = '{24'd0, 24'd0};                           send_batch(b);
    b.delete();
    for (int i = 0; i < 66; i++) b.insert(b.size(), SIZE_W'($urandom()));
    send_batch(b);
    while (items_sent < 300) begin
      b.delete();
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) b.insert(b.size(), rand_size());
      send_batch(b);
    end
    in_ch.valid <= 1'b0;
    sending_done = 1;
  end

  initial begin
    hold_off = 0;
    wait (items_sent > 90);
    wait (out_ch.valid);
    hold_off = 1;
    repeat (600) @(posedge clk);
    hold_off = 0;
  end

  initial begin
    level_result_t got;
    out_ch.ready = 0;
    @(negedge clk);
    forever begin
      if (hold_off) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 3) != 0);
      end
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        got.group_index = out_ch.group_index;
        got.size_class = out_ch.size_class;
        got.large_threshold = out_ch.large_threshold;
        got.medium_threshold = out_ch.medium_threshold;
        got.last_result = out_ch.last_result;
        levels.check_level(got);
      end
      @(negedge clk);
    end
  end

  initial begin
    wait (sending_done);
    while (levels.pending_levels.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (levels.errors == 0 && levels.pending_levels.size() == 0) begin
      $display("natural_break_scale_classifier regression: pass");
    end else begin
      $display("natural_break_scale_classifier regression: fail");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("natural_break_scale_classifier regression: fail");
    $finish;
  end
endmodule

[natural_break_scale_classifier.f]
design/nbsc_pkg.sv
design/nbsc_if.sv
design/nbsc_cdiv.sv
design/nbsc_isqrt.sv
design/nbsc_dp.sv
design/nbsc_ctrl.sv
design/natural_break_scale_classifier.sv
dv/nbsc_scoreboard.sv
dv/testbench.sv
